// ===== src/twqs_pkg.sv =====
// ----------------------------------------------------------------------------
// twqs_pkg
// Shared types for the three-way quicksort record sorter.
// ----------------------------------------------------------------------------
package twqs_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned PAY_W = 32;

  // One record as held in the store; key sits in the low bits.
  typedef struct packed {
    logic        [PAY_W-1:0] payload;
    logic signed [KEY_W-1:0] key;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT,
    S_POP,
    S_POP_WAIT,
    S_PIVOT,
    S_SCAN,
    S_CMP,
    S_SWAP,
    S_SWAP2,
    S_PUSH_HI,
    S_PUSH_LO,
    S_EMIT_RD,
    S_EMIT_LD
  } state_e;

endpackage

// ===== src/three_way_quicksort_records.sv =====
// ----------------------------------------------------------------------------
// three_way_quicksort_records
// Collects a batch of key/payload records, sorts it by signed key with
// three-way partitioning quicksort over a range stack, then streams it out.
// ----------------------------------------------------------------------------
//  Channel   Dir  tdata (low bit up)            tlast       Transfer
//  s_axis    in   key[31:0], payload[63:32]     last        tvalid & tready
//  m_axis    out  sorted_key[31:0],             final_res   tvalid & tready
//                 sorted_payload[63:32]
//
//  Loading accepts one record per cycle. The sort then runs in the record
//  store: the whole range is pushed; each pop reads the stack, then the pivot;
//  each scanned element is read and compared; an exchange writes two records;
//  the upper and lower ranges are pushed; it ends on an empty stack. Store and
//  stack RAM reads are registered, so emitting reads a record, then loads it.
//  s_axis_tready is high only while loading. A stalled m_axis holds the
//  current result and pauses the emit sequence. Reset empties the batch.
// ----------------------------------------------------------------------------
module three_way_quicksort_records #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key[31:0], payload[63:32]
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // sorted_key[31:0], sorted_payload[63:32]
  output logic        m_axis_tlast    // final_res
);

  localparam int unsigned IDX_W = $clog2(MAX_RECORDS);
  localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int unsigned STK_W = 2 * IDX_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECORDS);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

  twqs_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] sp_q, sp_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CNT_W-1:0] lt_q, lt_d, mid_q, mid_d, gt_q, gt_d;
  logic signed [twqs_pkg::KEY_W-1:0] pivot_q, pivot_d;
  twqs_pkg::rec_t rec_mid_q, rec_mid_d;
  logic dir_lt_q, dir_lt_d;
  logic out_valid_q, out_valid_d;
  twqs_pkg::rec_t out_rec_q, out_rec_d;
  logic out_last_q, out_last_d;

  // store RAM port
  logic           st_we;
  logic [IDX_W-1:0] st_waddr, st_raddr;
  twqs_pkg::rec_t st_wdata, st_rdata;

  // range stack RAM port
  logic             sk_we;
  logic [IDX_W-1:0] sk_waddr, sk_raddr;
  logic [STK_W-1:0] sk_wdata, sk_rdata;

  logic [CNT_W-1:0] sp_dec, lo_inc, lt_dec, cnt_dec;

  assign sp_dec  = sp_q - ONE;
  assign lo_inc  = lo_q + ONE;
  assign lt_dec  = lt_q - ONE;
  assign cnt_dec = cnt_q - ONE;

  twqs_ram #(
    .WIDTH (twqs_pkg::REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  twqs_ram #(
    .WIDTH (STK_W),
    .DEPTH (MAX_RECORDS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .waddr_i (sk_waddr),
    .wdata_i (sk_wdata),
    .raddr_i (sk_raddr),
    .rdata_o (sk_rdata)
  );

  assign s_axis_tready = (state_q == twqs_pkg::S_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_rec_q;
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sp_d        = sp_q;
    k_d         = k_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    lt_d        = lt_q;
    mid_d       = mid_q;
    gt_d        = gt_q;
    pivot_d     = pivot_q;
    rec_mid_d   = rec_mid_q;
    dir_lt_d    = dir_lt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_rec_d   = out_rec_q;
    out_last_d  = out_last_q;

    st_we    = 1'b0;
    st_waddr = mid_q[IDX_W-1:0];
    st_wdata = st_rdata;
    st_raddr = k_q[IDX_W-1:0];
    sk_we    = 1'b0;
    sk_waddr = sp_q[IDX_W-1:0];
    sk_wdata = {mid_q[IDX_W-1:0], hi_q[IDX_W-1:0]};
    sk_raddr = sp_dec[IDX_W-1:0];

    case (state_q)
      twqs_pkg::S_LOAD: begin
        if (s_axis_tvalid) begin
          if (cnt_q < MAX_CNT) begin
            st_we    = 1'b1;
            st_waddr = cnt_q[IDX_W-1:0];
            st_wdata = twqs_pkg::rec_t'(s_axis_tdata);
            cnt_d    = cnt_q + ONE;
          end
          if (s_axis_tlast) begin
            state_d = twqs_pkg::S_INIT;
          end
        end
      end
      twqs_pkg::S_INIT: begin
        k_d  = '0;
        sp_d = '0;
        if (cnt_q > ONE) begin
          sk_we    = 1'b1;
          sk_waddr = '0;
          sk_wdata = {{IDX_W{1'b0}}, cnt_dec[IDX_W-1:0]};
          sp_d     = ONE;
          state_d  = twqs_pkg::S_POP;
        end else begin
          state_d = twqs_pkg::S_EMIT_RD;
        end
      end
      twqs_pkg::S_POP: begin
        if (sp_q == '0) begin
          state_d = twqs_pkg::S_EMIT_RD;
        end else begin
          sp_d    = sp_dec;
          state_d = twqs_pkg::S_POP_WAIT;
        end
      end
      twqs_pkg::S_POP_WAIT: begin
        lo_d     = CNT_W'(sk_rdata[STK_W-1:IDX_W]);
        hi_d     = CNT_W'(sk_rdata[IDX_W-1:0]);
        lt_d     = CNT_W'(sk_rdata[STK_W-1:IDX_W]);
        mid_d    = CNT_W'(sk_rdata[STK_W-1:IDX_W]);
        gt_d     = CNT_W'(sk_rdata[IDX_W-1:0]);
        st_raddr = sk_rdata[STK_W-1:IDX_W];
        state_d  = twqs_pkg::S_PIVOT;
      end
      twqs_pkg::S_PIVOT: begin
        pivot_d = st_rdata.key;
        state_d = twqs_pkg::S_SCAN;
      end
      twqs_pkg::S_SCAN: begin
        if (mid_q <= gt_q) begin
          st_raddr = mid_q[IDX_W-1:0];
          state_d  = twqs_pkg::S_CMP;
        end else begin
          state_d = twqs_pkg::S_PUSH_HI;
        end
      end
      twqs_pkg::S_CMP: begin
        rec_mid_d = st_rdata;
        if (st_rdata.key < pivot_q) begin
          dir_lt_d = 1'b1;
          st_raddr = lt_q[IDX_W-1:0];
          state_d  = twqs_pkg::S_SWAP;
        end else if (st_rdata.key > pivot_q) begin
          dir_lt_d = 1'b0;
          st_raddr = gt_q[IDX_W-1:0];
          state_d  = twqs_pkg::S_SWAP;
        end else begin
          mid_d   = mid_q + ONE;
          state_d = twqs_pkg::S_SCAN;
        end
      end
      twqs_pkg::S_SWAP: begin
        // partner record lands at mid
        st_we    = 1'b1;
        st_waddr = mid_q[IDX_W-1:0];
        st_wdata = st_rdata;
        state_d  = twqs_pkg::S_SWAP2;
      end
      twqs_pkg::S_SWAP2: begin
        st_we    = 1'b1;
        st_waddr = dir_lt_q ? lt_q[IDX_W-1:0] : gt_q[IDX_W-1:0];
        st_wdata = rec_mid_q;
        if (dir_lt_q) begin
          lt_d  = lt_q + ONE;
          mid_d = mid_q + ONE;
        end else begin
          gt_d = gt_q - ONE;
        end
        state_d = twqs_pkg::S_SCAN;
      end
      twqs_pkg::S_PUSH_HI: begin
        if (mid_q < hi_q && sp_q < MAX_CNT) begin
          sk_we    = 1'b1;
          sk_wdata = {mid_q[IDX_W-1:0], hi_q[IDX_W-1:0]};
          sp_d     = sp_q + ONE;
        end
        state_d = twqs_pkg::S_PUSH_LO;
      end
      twqs_pkg::S_PUSH_LO: begin
        if (lo_inc < lt_q && sp_q < MAX_CNT) begin
          sk_we    = 1'b1;
          sk_wdata = {lo_q[IDX_W-1:0], lt_dec[IDX_W-1:0]};
          sp_d     = sp_q + ONE;
        end
        state_d = twqs_pkg::S_POP;
      end
      twqs_pkg::S_EMIT_RD: begin
        // read only once the output register frees up next cycle
        if (!out_valid_q || m_axis_tready) begin
          state_d = twqs_pkg::S_EMIT_LD;
        end
      end
      twqs_pkg::S_EMIT_LD: begin
        out_valid_d = 1'b1;
        out_rec_d   = st_rdata;
        out_last_d  = (k_q == cnt_dec);
        k_d         = k_q + ONE;
        if (k_q == cnt_dec) begin
          cnt_d   = '0;
          sp_d    = '0;
          state_d = twqs_pkg::S_LOAD;
        end else begin
          state_d = twqs_pkg::S_EMIT_RD;
        end
      end
      default: begin
        state_d = twqs_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= twqs_pkg::S_LOAD;
      cnt_q       <= '0;
      sp_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sp_q        <= sp_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    lt_q       <= lt_d;
    mid_q      <= mid_d;
    gt_q       <= gt_d;
    pivot_q    <= pivot_d;
    rec_mid_q  <= rec_mid_d;
    dir_lt_q   <= dir_lt_d;
    out_rec_q  <= out_rec_d;
    out_last_q <= out_last_d;
  end

endmodule

// ===== src/twqs_ram.sv =====
// ----------------------------------------------------------------------------
// twqs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module twqs_ram #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
